// File: hdl/edge_hash_table_defines.svh
// Assertion macros used by the edge hash table datapath
`ifndef EDGE_HASH_TABLE_DEFINES_SVH
`define EDGE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define EHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/eht_pkg.sv
// Package: codes, hash constant and controller/datapath interface types
package eht_pkg;

    localparam logic [31:0] HASH_MUL = 32'h9e3779b9;

    localparam logic [2:0] FN_ADD    = 3'd0;
    localparam logic [2:0] FN_FIND   = 3'd1;
    localparam logic [2:0] FN_REMSYM = 3'd2;
    localparam logic [2:0] FN_REMST  = 3'd3;
    localparam logic [2:0] FN_REPL   = 3'd4;
    localparam logic [2:0] FN_REBASE = 3'd5;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_PRESENT  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [1:0] TAG_UNUSED = 2'd0;
    localparam logic [1:0] TAG_LIVE   = 2'd1;
    localparam logic [1:0] TAG_TOMB   = 2'd2;

    localparam logic [6:0] MAX_RESET = 7'd32;

    typedef struct packed {
        logic clr;
        logic ld;
        logic hash;
        logic rd;
        logic ev;
        logic sclr;
        logic srd;
        logic sev;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic last;
        logic stop;
        logic need_seen;
        logic more_pass;
        logic is_add;
        logic seen_last;
    } t_sts;

endpackage

// File: hdl/eht_ctrl.sv
// Controller state machine for the edge hash table
module eht_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic [2:0]    i_func,
    input  eht_pkg::t_sts i_sts,
    output eht_pkg::t_cmd o_cmd,
    output logic          busy,
    output logic          o_valid
);
    import eht_pkg::*;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_HASH = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_EV   = 4'd4;
    localparam logic [3:0] S_SCLR = 4'd5;
    localparam logic [3:0] S_SRD  = 4'd6;
    localparam logic [3:0] S_SEV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.ld = 1'b1;
                    case (i_func) inside
                        FN_ADD, FN_FIND, FN_REMSYM: n_state = S_HASH;
                        FN_REMST, FN_REPL, FN_REBASE: n_state = S_RD;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_HASH: begin
                o_cmd.hash = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                o_cmd.ev = 1'b1;
                if (i_sts.need_seen) begin
                    n_state = S_SRD;
                end else if (i_sts.stop || i_sts.last) begin
                    if (i_sts.more_pass) begin
                        n_state = S_SCLR;
                    end else if (i_sts.is_add) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_SCLR: begin
                o_cmd.sclr = 1'b1;
                if (i_sts.seen_last) begin
                    n_state = S_RD;
                end
            end
            S_SRD: begin
                o_cmd.srd = 1'b1;
                n_state   = S_SEV;
            end
            S_SEV: begin
                o_cmd.sev = 1'b1;
                n_state   = i_sts.last ? S_DONE : S_RD;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// File: hdl/eht_dp.sv
// Datapath: bucket memories, seen-symbol memory, hash unit and counters
`include "edge_hash_table_defines.svh"
module eht_dp #(
    parameter int TABLE_SIZE = 64,
    parameter int STATE_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  eht_pkg::t_cmd i_cmd,
    output eht_pkg::t_sts o_sts,
    input  logic [2:0]    i_func,
    input  logic [7:0]    i_symbol,
    input  logic [15:0]   i_state_arg,
    input  logic [15:0]   i_new_state,
    input  logic          i_cfg_we,
    input  logic [6:0]    i_cfg_wdata,
    output logic [2:0]    o_status,
    output logic [15:0]   o_found_state,
    output logic [6:0]    o_entry_total
);
    import eht_pkg::*;

    localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int XS = (STATE_BITS > 16) ? STATE_BITS : 16;
    localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

    // home bucket of every symbol, worked out at elaboration
    function automatic logic [256*AW-1:0] build_home();
        logic [256*AW-1:0] t;
        logic [31:0]       h;
        t = '0;
        for (int s = 0; s < 256; s++) begin
            h = HASH_MUL * 32'(s);
            t[s*AW +: AW] = AW'(h % 32'(TABLE_SIZE));
        end
        return t;
    endfunction

    localparam logic [256*AW-1:0] HOME_TAB = build_home();

    logic [1:0]            m_tag  [TABLE_SIZE];
    logic [7:0]            m_sym  [TABLE_SIZE];
    logic [STATE_BITS-1:0] m_st   [TABLE_SIZE];
    logic                  m_seen [256];

    logic [2:0]            r_func;
    logic [7:0]            r_sym;
    logic [STATE_BITS-1:0] r_arg, r_nst, r_found;
    logic [6:0]            r_max;
    logic [CW-1:0]         r_count;
    logic [AW-1:0]         r_idx, r_steps, r_cidx, r_tomb, r_slot;
    logic [7:0]            r_sidx;
    logic                  r_phase, r_have_tomb, r_have_slot, r_present;
    logic [2:0]            r_status;
    logic [1:0]            r_rd_tag;
    logic [7:0]            r_rd_sym;
    logic [STATE_BITS-1:0] r_rd_st;
    logic                  r_rd_seen;

    logic [XS-1:0]         arg_x, nst_x, found_x;
    logic [XW-1:0]         cnt_x, max_x;
    logic [AW-1:0]         idx_inc;
    logic [CW-1:0]         count_dn;
    logic                  live, hit_sym, hit_st, hit_nst;
    logic                  stop, need_seen, kill, wr_st, add_ok, ev_end;
    logic [STATE_BITS-1:0] st_d;
    logic [AW-1:0]         w_addr;
    logic                  tag_we, sym_we, st_we;
    logic [1:0]            tag_d;
    logic                  seen_we, seen_d;
    logic [7:0]            seen_addr;

    assign arg_x   = XS'(i_state_arg);
    assign nst_x   = XS'(i_new_state);
    assign found_x = XS'(r_found);
    assign cnt_x   = XW'(r_count);
    assign max_x   = XW'(r_max);

    assign idx_inc = (r_idx == LAST_IDX) ? '0 : (r_idx + 1'b1);
    assign count_dn = (r_count != '0) ? (r_count - 1'b1) : r_count;

    assign live    = (r_rd_tag == TAG_LIVE);
    assign hit_sym = live && (r_rd_sym == r_sym);
    assign hit_st  = live && (r_rd_st == r_arg);
    assign hit_nst = live && (r_rd_st == r_nst);
    assign add_ok  = !r_present && (cnt_x < max_x) && (r_have_tomb || r_have_slot);

    always_comb begin
        stop      = 1'b0;
        need_seen = 1'b0;
        kill      = 1'b0;
        wr_st     = 1'b0;
        st_d      = r_nst;
        case (r_func)
            FN_ADD:    stop = (r_rd_tag == TAG_UNUSED) || (hit_st && hit_sym);
            FN_FIND:   stop = (r_rd_tag == TAG_UNUSED) || hit_sym;
            FN_REMSYM: begin
                stop = (r_rd_tag == TAG_UNUSED);
                kill = hit_sym;
            end
            FN_REMST:  kill = hit_st;
            FN_REPL: begin
                if (!r_phase) begin
                    wr_st = hit_st;
                end else begin
                    need_seen = hit_nst;
                end
            end
            FN_REBASE: begin
                wr_st = live;
                st_d  = r_rd_st + r_arg;
            end
            default: ;
        endcase
    end

    assign ev_end = stop || (r_steps == LAST_IDX);

    // single write port on the bucket memories
    always_comb begin
        w_addr = r_idx;
        tag_we = 1'b0;
        sym_we = 1'b0;
        st_we  = 1'b0;
        tag_d  = TAG_TOMB;
        if (i_cmd.clr) begin
            w_addr = r_cidx;
            tag_we = 1'b1;
            tag_d  = TAG_UNUSED;
        end else if (i_cmd.fin) begin
            w_addr = r_have_tomb ? r_tomb : r_slot;
            tag_we = add_ok;
            sym_we = add_ok;
            st_we  = add_ok;
            tag_d  = TAG_LIVE;
        end else if (i_cmd.ev) begin
            tag_we = kill;
            st_we  = wr_st;
        end else if (i_cmd.sev) begin
            tag_we = r_rd_seen;
        end
    end

    always_comb begin
        seen_we   = 1'b0;
        seen_d    = 1'b1;
        seen_addr = r_rd_sym;
        if (i_cmd.sclr) begin
            seen_we   = 1'b1;
            seen_d    = 1'b0;
            seen_addr = r_sidx;
        end else if (i_cmd.sev) begin
            seen_we = !r_rd_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            m_tag[w_addr] <= tag_d;
        end
        if (sym_we) begin
            m_sym[w_addr] <= r_sym;
        end
        if (st_we) begin
            m_st[w_addr] <= i_cmd.fin ? r_arg : st_d;
        end
        if (i_cmd.rd) begin
            r_rd_tag <= m_tag[r_idx];
            r_rd_sym <= m_sym[r_idx];
            r_rd_st  <= m_st[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) begin
            m_seen[seen_addr] <= seen_d;
        end
        if (i_cmd.srd) begin
            r_rd_seen <= m_seen[r_rd_sym];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= MAX_RESET;
            r_count <= '0;
            r_cidx  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            if (i_cmd.clr) begin
                r_cidx <= r_cidx + 1'b1;
            end
            if ((i_cmd.ev && kill) || (i_cmd.sev && r_rd_seen)) begin
                r_count <= count_dn;
            end else if (i_cmd.fin && add_ok) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld) begin
            r_func      <= i_func;
            r_sym       <= i_symbol;
            r_arg       <= arg_x[STATE_BITS-1:0];
            r_nst       <= nst_x[STATE_BITS-1:0];
            r_idx       <= '0;
            r_steps     <= '0;
            r_sidx      <= '0;
            r_phase     <= 1'b0;
            r_have_tomb <= 1'b0;
            r_have_slot <= 1'b0;
            r_present   <= 1'b0;
            r_found     <= '0;
            r_status    <= (i_func == FN_FIND) ? ST_NOTFOUND : ST_DONE;
        end
        if (i_cmd.hash) begin
            r_idx <= HOME_TAB[r_sym*AW +: AW];
        end
        if (i_cmd.sclr) begin
            r_sidx <= r_sidx + 1'b1;
        end
        if (i_cmd.ev) begin
            if (r_func == FN_ADD) begin
                if (r_rd_tag == TAG_TOMB && !r_have_tomb) begin
                    r_have_tomb <= 1'b1;
                    r_tomb      <= r_idx;
                end
                if (r_rd_tag == TAG_UNUSED) begin
                    r_have_slot <= 1'b1;
                    r_slot      <= r_idx;
                end
                if (hit_st && hit_sym) begin
                    r_present <= 1'b1;
                end
            end
            if (r_func == FN_FIND && hit_sym) begin
                r_status <= ST_FOUND;
                r_found  <= r_rd_st;
            end
            if (!need_seen) begin
                if (ev_end) begin
                    if (r_func == FN_REPL && !r_phase) begin
                        r_phase <= 1'b1;
                        r_idx   <= '0;
                        r_steps <= '0;
                    end
                end else begin
                    r_idx   <= idx_inc;
                    r_steps <= r_steps + 1'b1;
                end
            end
        end
        if (i_cmd.sev) begin
            r_idx   <= idx_inc;
            r_steps <= r_steps + 1'b1;
        end
        if (i_cmd.fin) begin
            r_status <= r_present ? ST_PRESENT : (add_ok ? ST_DONE : ST_FULL);
        end
    end

    assign o_sts.clr_last  = (r_cidx == LAST_IDX);
    assign o_sts.last      = (r_steps == LAST_IDX);
    assign o_sts.stop      = stop;
    assign o_sts.need_seen = need_seen;
    assign o_sts.more_pass = (r_func == FN_REPL) && !r_phase;
    assign o_sts.is_add    = (r_func == FN_ADD);
    assign o_sts.seen_last = (r_sidx == 8'hff);

    assign o_status      = r_status;
    assign o_found_state = found_x[15:0];
    assign o_entry_total = cnt_x[6:0];

    `EHT_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(TABLE_SIZE), "live count above table size")
    `EHT_ASSERT_NXT(a_add_count, i_clk, i_rst_n, i_cmd.fin && add_ok, r_count == $past(r_count) + 1'b1, "add did not bump count")
    `EHT_ASSERT_NXT(a_ld_steps, i_clk, i_rst_n, i_cmd.ld, r_steps == '0 && r_phase == 1'b0, "probe state not cleared on load")

endmodule

// File: hdl/edge_hash_table.sv
// Top level: edge hash table with linear probing and tombstones
// Usage:
//   Commands: raise start with func, symbol, state_arg and new_state while busy is low;
//   the item is taken on that edge and busy stays high until the result is given.
//   Results: o_valid strobes for one cycle with o_status, o_found_state and
//   o_entry_total; the receiver cannot hold it off and none is needed.
//   Config: i_cfg_we with i_cfg_wdata writes max_entries (reset 32); the user must
//   do so only when idle, as the block itself does not enforce it.
//   Steps: add, find and remove symbol look up the home bucket, read and evaluate
//   each probed bucket in turn and then give the result; add has a finish step
//   that writes the new entry when it is new and there is room. Remove state and
//   rebase read and evaluate every bucket; replace does so twice, with a clear of
//   the seen-symbol memory between, plus a seen-symbol read and update for each
//   live edge holding the new state. Unknown func codes go straight to the result
//   with status done. One item at a time, with a single write port on the bucket
//   memories; the next item is taken in the cycle after the result at the earliest.
//   Reset: a clearing pass marks every bucket unused; busy is high during it.
module edge_hash_table #(
    parameter int TABLE_SIZE = 64,
    parameter int STATE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_symbol,
    input  logic [15:0] i_state_arg,
    input  logic [15:0] i_new_state,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [15:0] o_found_state,
    output logic [6:0]  o_entry_total
);
    import eht_pkg::*;

    t_cmd cmd;
    t_sts sts;

    eht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    eht_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .STATE_BITS (STATE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_symbol      (i_symbol),
        .i_state_arg   (i_state_arg),
        .i_new_state   (i_new_state),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_status      (o_status),
        .o_found_state (o_found_state),
        .o_entry_total (o_entry_total)
    );

endmodule
